// File: src/bpcc_pkg.sv
// Shared constants, codes and interface types of the blocked-PRB collision check.
`default_nettype none
package bpcc_pkg;

   localparam int PRB_COUNT  = 275;
   localparam int MARGIN_MAX = 15;

   // fixed field widths of the channels
   localparam int PRB_W    = 9;
   localparam int END_W    = PRB_W + 1;
   localparam int GUARD_W  = 4;
   localparam int ID_W     = 16;
   localparam int KIND_W   = 2;
   localparam int TOTAL_W  = 16;
   localparam int CSR_IDX_W = 2;

   // widths that follow from the band and the margin limit
   localparam int ADDR_W = $clog2(PRB_COUNT);
   localparam int CNT_W  = $clog2(PRB_COUNT + 1);
   localparam int MARG_W = $clog2(MARGIN_MAX + 1);
   localparam int WIN_W  = 2 * MARGIN_MAX + 1;
   localparam int SCAN_W = $clog2(PRB_COUNT + MARGIN_MAX + 1) + 1;

   typedef logic [1:0] op_type;
   localparam op_type OP_WRITE = 2'd0;
   localparam op_type OP_BEGIN = 2'd1;
   localparam op_type OP_CHECK = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_GUARD  = 2'd0;
   localparam csr_idx_type CSR_DL_ACT = 2'd1;
   localparam csr_idx_type CSR_UL_ACT = 2'd2;

   typedef logic signed [SCAN_W-1:0] scan_pos_type;

   typedef struct packed {
      logic              en;
      logic              dir;
      logic [ADDR_W-1:0] addr;
      logic              value;
   } mask_wr_type;

   typedef struct packed {
      logic              dir;
      scan_pos_type      q_start;   // first mask position read
      scan_pos_type      q_end;     // last mask position read
      scan_pos_type      q_decide;  // first position at which a PRB is decided
      logic [ADDR_W-1:0] p_start;   // first PRB of the clipped range
      logic [WIN_W-1:0]  win_mask;  // low 2*margin+1 bits set
   } scan_cmd_type;

   typedef struct packed {
      logic clearing;
      logic done;
   } scan_stat_type;

endpackage
`default_nettype wire

// File: src/bpcc_scan.sv
// Mask memories with clearing pass and the bit-serial guard-window scan engine.
`default_nettype none
module bpcc_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  bpcc_pkg::mask_wr_type          mask_wr,
   input  logic                           start,
   input  bpcc_pkg::scan_cmd_type         cmd,
   output bpcc_pkg::scan_stat_type        stat,
   output logic [bpcc_pkg::CNT_W-1:0]     count,
   output logic [bpcc_pkg::ADDR_W-1:0]    first
);

   logic dl_mem_ff [bpcc_pkg::PRB_COUNT];
   logic ul_mem_ff [bpcc_pkg::PRB_COUNT];
   logic rd_ff;

   logic                          clr_ff;
   logic [bpcc_pkg::ADDR_W-1:0]   clr_addr_ff;

   bpcc_pkg::scan_cmd_type        cmd_ff;
   logic                          run_ff;
   logic                          vld_d_ff;
   logic                          last_d_ff;
   logic                          done_ff;
   bpcc_pkg::scan_pos_type        q_ff;
   bpcc_pkg::scan_pos_type        q_d_ff;
   logic                          inb_d_ff;
   logic [bpcc_pkg::WIN_W-1:0]    win_ff;
   logic [bpcc_pkg::CNT_W-1:0]    count_ff;
   logic [bpcc_pkg::ADDR_W-1:0]   first_ff;
   logic [bpcc_pkg::ADDR_W-1:0]   p_ff;

   logic                          inb;
   logic                          last;
   logic [bpcc_pkg::ADDR_W-1:0]   rd_addr;
   logic                          blocked;
   logic [bpcc_pkg::WIN_W-1:0]    win_in;
   logic                          decide;
   logic                          widened;
   logic                          take;

   assign inb     = !q_ff[bpcc_pkg::SCAN_W-1] &&
                    (q_ff < bpcc_pkg::scan_pos_type'(bpcc_pkg::PRB_COUNT));
   assign last    = (q_ff == cmd_ff.q_end);
   assign rd_addr = q_ff[bpcc_pkg::ADDR_W-1:0];

   // positions outside the band read as not blocked
   assign blocked = inb_d_ff & rd_ff;
   assign win_in  = {win_ff[bpcc_pkg::WIN_W-2:0], blocked};
   assign widened = |(win_in & cmd_ff.win_mask);
   assign decide  = vld_d_ff && (q_d_ff >= cmd_ff.q_decide);
   assign take    = decide && widened;

   // memories: clearing pass after reset, then single-bit writes
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         dl_mem_ff[clr_addr_ff] <= 1'b0;
         ul_mem_ff[clr_addr_ff] <= 1'b0;
      end else if (mask_wr.en) begin
         if (mask_wr.dir) begin
            ul_mem_ff[mask_wr.addr] <= mask_wr.value;
         end else begin
            dl_mem_ff[mask_wr.addr] <= mask_wr.value;
         end
      end
      rd_ff <= cmd_ff.dir ? ul_mem_ff[rd_addr] : dl_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         if (clr_addr_ff == bpcc_pkg::ADDR_W'(bpcc_pkg::PRB_COUNT - 1)) begin
            clr_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         vld_d_ff  <= 1'b0;
         last_d_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && last) begin
            run_ff <= 1'b0;
         end
         vld_d_ff  <= run_ff;
         last_d_ff <= run_ff && last;
         done_ff   <= vld_d_ff && last_d_ff;
      end
   end

   // scan datapath: one mask bit per cycle through the guard window
   always_ff @(posedge clock) begin
      if (start) begin
         cmd_ff   <= cmd;
         q_ff     <= cmd.q_start;
         win_ff   <= '0;
         count_ff <= '0;
         first_ff <= '0;
         p_ff     <= cmd.p_start;
      end else begin
         if (run_ff) begin
            q_ff <= q_ff + 1'b1;
         end
         if (vld_d_ff) begin
            win_ff <= win_in;
         end
         if (decide) begin
            p_ff <= p_ff + 1'b1;
         end
         if (take) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == '0) begin
               first_ff <= p_ff;
            end
         end
      end
      q_d_ff   <= q_ff;
      inb_d_ff <= inb;
   end

   assign stat.clearing = clr_ff;
   assign stat.done     = done_ff;
   assign count         = count_ff;
   assign first         = first_ff;

endmodule
`default_nettype wire

// File: src/blocked_prb_collision_check_unit.sv
// Top level of the blocked-PRB collision check: channels, registers and walk state.
//
// Use: items arrive as req_ beats; req_op selects a mask bit write, the start of
// a walk, or an allocation check. Only a check gives a result beat on rsp_.
// Registers are written through csr_wr_en / csr_index / csr_wdata; the user must
// write them only while idle, which the block itself does not enforce:
// index 0 guard margin, 1 downlink block active, 2 uplink block active. A check
// whose direction is inactive, whose owner does not match, or whose range is
// empty goes from idle to the done state without a scan. Otherwise the mask
// memory is read one PRB per cycle over the range widened by the margin on both
// sides; the mask memory has a single read port.
// After reset both masks are cleared by a pass over all PRB_COUNT (275) entries, one
// entry per cycle; req_ready stays low during it while register writes are taken.
// A finished result waits in the output register while rsp_ready is low; mask
// writes and walk starts are still taken, and a new check may scan meanwhile
// but holds its result until the output register frees up.
`default_nettype none
module blocked_prb_collision_check_unit (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             csr_wr_en,
   input  logic [bpcc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpcc_pkg::GUARD_W-1:0]     csr_wdata,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_op,
   input  logic                             req_direction,
   input  logic [bpcc_pkg::PRB_W-1:0]       req_prb_index,
   input  logic                             req_blocked_bit,
   input  logic [bpcc_pkg::PRB_W-1:0]       req_range_start,
   input  logic [bpcc_pkg::PRB_W-1:0]       req_range_count,
   input  logic [bpcc_pkg::KIND_W-1:0]      req_signal_kind,
   input  logic [bpcc_pkg::ID_W-1:0]        req_radio_id,
   input  logic                             req_event_kind,
   input  logic [bpcc_pkg::ID_W-1:0]        req_user_id,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic [bpcc_pkg::PRB_W-1:0]       rsp_overlap_count,
   output logic [bpcc_pkg::PRB_W-1:0]       rsp_first_overlap,
   output logic [bpcc_pkg::KIND_W-1:0]      rsp_signal_out,
   output logic [bpcc_pkg::ID_W-1:0]        rsp_radio_out,
   output logic [bpcc_pkg::PRB_W-1:0]       rsp_range_start_out,
   output logic [bpcc_pkg::PRB_W-1:0]       rsp_range_count_out,
   output logic                             rsp_event_out,
   output logic [bpcc_pkg::TOTAL_W-1:0]     rsp_walk_total
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type                         state_ff;

   // registers
   logic [bpcc_pkg::GUARD_W-1:0]      guard_ff;
   logic                              dl_act_ff;
   logic                              ul_act_ff;

   // walk state
   logic [bpcc_pkg::TOTAL_W-1:0]      total_ff;
   logic                              walk_event_ff;
   logic [bpcc_pkg::ID_W-1:0]         walk_user_ff;

   // captured check beat and its result
   logic [bpcc_pkg::KIND_W-1:0]       sig_ff;
   logic [bpcc_pkg::ID_W-1:0]         radio_ff;
   logic [bpcc_pkg::PRB_W-1:0]        rstart_ff;
   logic [bpcc_pkg::PRB_W-1:0]        rcount_ff;
   logic [bpcc_pkg::CNT_W-1:0]        res_count_ff;
   logic [bpcc_pkg::ADDR_W-1:0]       res_first_ff;

   // output register
   logic                              rsp_valid_ff;
   logic                              rsp_hit_ff;
   logic [bpcc_pkg::PRB_W-1:0]        rsp_count_ff;
   logic [bpcc_pkg::PRB_W-1:0]        rsp_first_ff;
   logic [bpcc_pkg::KIND_W-1:0]       rsp_sig_ff;
   logic [bpcc_pkg::ID_W-1:0]         rsp_radio_ff;
   logic [bpcc_pkg::PRB_W-1:0]        rsp_rstart_ff;
   logic [bpcc_pkg::PRB_W-1:0]        rsp_rcount_ff;
   logic                              rsp_event_ff;
   logic [bpcc_pkg::TOTAL_W-1:0]      rsp_total_ff;

   bpcc_pkg::scan_stat_type           stat;
   bpcc_pkg::scan_cmd_type            cmd;
   bpcc_pkg::mask_wr_type             mask_wr;
   logic [bpcc_pkg::CNT_W-1:0]        scan_count;
   logic [bpcc_pkg::ADDR_W-1:0]       scan_first;

   logic                              accept;
   logic                              scan_start;
   logic                              checked;
   logic                              nonempty;
   logic [bpcc_pkg::MARG_W-1:0]       margin;
   logic [bpcc_pkg::END_W-1:0]        end_sum;
   logic [bpcc_pkg::END_W-1:0]        end_clip;
   logic                              out_free;
   logic                              res_hit;
   logic [bpcc_pkg::TOTAL_W-1:0]      total_in;

   assign req_ready = (state_ff == ST_IDLE) && !stat.clearing;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // clamp the margin to the supported window
   assign margin = (int'(guard_ff) > bpcc_pkg::MARGIN_MAX) ?
                   bpcc_pkg::MARG_W'(bpcc_pkg::MARGIN_MAX) : bpcc_pkg::MARG_W'(guard_ff);

   // clip the range to the band
   assign end_sum  = {1'b0, req_range_start} + {1'b0, req_range_count};
   assign end_clip = (end_sum > bpcc_pkg::END_W'(bpcc_pkg::PRB_COUNT)) ?
                     bpcc_pkg::END_W'(bpcc_pkg::PRB_COUNT) : end_sum;
   assign nonempty = {1'b0, req_range_start} < end_clip;

   // inactive direction or foreign owner in a reconfiguration walk: no overlap
   assign checked = (req_direction ? ul_act_ff : dl_act_ff) &&
                    !(walk_event_ff && (req_user_id != walk_user_ff));

   assign scan_start = accept && (req_op == bpcc_pkg::OP_CHECK) && checked && nonempty;

   // read from start - margin up to end - 1 + margin; decide PRBs margin behind
   always_comb begin
      cmd.dir      = req_direction;
      cmd.q_start  = bpcc_pkg::scan_pos_type'(req_range_start) -
                     bpcc_pkg::scan_pos_type'(margin);
      cmd.q_end    = bpcc_pkg::scan_pos_type'(end_clip) - 1'b1 +
                     bpcc_pkg::scan_pos_type'(margin);
      cmd.q_decide = bpcc_pkg::scan_pos_type'(req_range_start) +
                     bpcc_pkg::scan_pos_type'(margin);
      cmd.p_start  = req_range_start[bpcc_pkg::ADDR_W-1:0];
      cmd.win_mask = ~({bpcc_pkg::WIN_W{1'b1}} << {margin, 1'b1});
   end

   always_comb begin
      mask_wr.en    = accept && (req_op == bpcc_pkg::OP_WRITE) &&
                      ({1'b0, req_prb_index} < bpcc_pkg::END_W'(bpcc_pkg::PRB_COUNT));
      mask_wr.dir   = req_direction;
      mask_wr.addr  = req_prb_index[bpcc_pkg::ADDR_W-1:0];
      mask_wr.value = req_blocked_bit;
   end

   assign res_hit  = (res_count_ff != '0);
   assign total_in = (res_hit && (total_ff != '1)) ? total_ff + 1'b1 : total_ff;

   bpcc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .mask_wr (mask_wr),
      .start   (scan_start),
      .cmd     (cmd),
      .stat    (stat),
      .count   (scan_count),
      .first   (scan_first)
   );

   // registers: write while idle, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff  <= '0;
         dl_act_ff <= 1'b0;
         ul_act_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bpcc_pkg::CSR_GUARD:  guard_ff  <= csr_wdata;
            bpcc_pkg::CSR_DL_ACT: dl_act_ff <= csr_wdata[0];
            bpcc_pkg::CSR_UL_ACT: ul_act_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer, walk state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
         walk_event_ff <= 1'b0;
         walk_user_ff  <= '0;
      end else begin
         // drop a delivered beat; a new load below overrides
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_op)
                     bpcc_pkg::OP_BEGIN: begin
                        total_ff      <= '0;
                        walk_event_ff <= req_event_kind;
                        walk_user_ff  <= req_user_id;
                     end
                     bpcc_pkg::OP_CHECK: begin
                        state_ff <= (checked && nonempty) ? ST_SCAN : ST_DONE;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               if (stat.done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold the result until the output register is free
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  total_ff     <= total_in;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload: capture the check beat, its result, and the output beat
   always_ff @(posedge clock) begin
      if (accept && (req_op == bpcc_pkg::OP_CHECK)) begin
         sig_ff       <= req_signal_kind;
         radio_ff     <= req_radio_id;
         rstart_ff    <= req_range_start;
         rcount_ff    <= req_range_count;
         res_count_ff <= '0;
         res_first_ff <= '0;
      end
      if ((state_ff == ST_SCAN) && stat.done) begin
         res_count_ff <= scan_count;
         res_first_ff <= scan_first;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_hit_ff    <= res_hit;
         rsp_count_ff  <= bpcc_pkg::PRB_W'(res_count_ff);
         rsp_first_ff  <= bpcc_pkg::PRB_W'(res_first_ff);
         rsp_sig_ff    <= sig_ff;
         rsp_radio_ff  <= radio_ff;
         rsp_rstart_ff <= rstart_ff;
         rsp_rcount_ff <= rcount_ff;
         rsp_event_ff  <= walk_event_ff;
         rsp_total_ff  <= total_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_overlap_count   = rsp_count_ff;
   assign rsp_first_overlap   = rsp_first_ff;
   assign rsp_signal_out      = rsp_sig_ff;
   assign rsp_radio_out       = rsp_radio_ff;
   assign rsp_range_start_out = rsp_rstart_ff;
   assign rsp_range_count_out = rsp_rcount_ff;
   assign rsp_event_out       = rsp_event_ff;
   assign rsp_walk_total      = rsp_total_ff;

endmodule
`default_nettype wire

// File: src/bpcc_checker.sv
// Port-level assertions of the blocked-PRB collision check and their bind.
`default_nettype none
module bpcc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_hit,
   input logic [bpcc_pkg::PRB_W-1:0]      rsp_overlap_count,
   input logic [bpcc_pkg::PRB_W-1:0]      rsp_first_overlap,
   input logic [bpcc_pkg::TOTAL_W-1:0]    rsp_walk_total
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_overlap_count) &&
      $stable(rsp_walk_total) && $stable(rsp_first_overlap))
      else $error("stalled result beat changed");

   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_overlap_count != '0)))
      else $error("hit disagrees with overlap count");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> (rsp_first_overlap == '0))
      else $error("first overlap set without a hit");

   a_total_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> (rsp_walk_total != '0))
      else $error("hit beat with zero walk total");

endmodule

bind blocked_prb_collision_check_unit bpcc_checker u_bpcc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_hit           (rsp_hit),
   .rsp_overlap_count (rsp_overlap_count),
   .rsp_first_overlap (rsp_first_overlap),
   .rsp_walk_total    (rsp_walk_total)
);
`default_nettype wire
